### rtl/core/aise_pkg.sv
// ----------------------------------------------------------------------------
// aise_pkg : shared types for the array insert / search / edit engine
// Command and status codes, word structs for both channels and the
// per-cell operation code driven along the cell row.
// ----------------------------------------------------------------------------
package aise_pkg;

    localparam int DEPTH_DEF = 512;   // default number of cells
    localparam int FIELD_W   = 10;    // width of position and count fields
    localparam int DATA_W    = 32;    // width of one held value

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_EDIT   = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_POS  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic [FIELD_W-1:0]         position;
        logic signed [DATA_W-1:0]   value;
    } aise_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0]         match_count;
        logic [FIELD_W-1:0]         length;
        status_t                    status;
    } aise_out_t;

    // what every cell does in a given cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_EDIT   = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

endpackage

### rtl/core/aise_cell.sv
// ----------------------------------------------------------------------------
// aise_cell : one storage cell of the row
// Holds one value; takes its left neighbour on insert shift, its right
// neighbour on rotate, or the new data when its index is the target.
// ----------------------------------------------------------------------------
module aise_cell
    import aise_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 9
)
(
    input  logic                     clk,
    input  cell_op_t                 op,
    input  logic [IW-1:0]            slot,
    input  logic signed [DATA_W-1:0] data,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] q
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        unique case (op)
            CELL_HOLD:
            begin
                q_next = q_reg;
            end
            CELL_INSERT:
            begin
                if (MY_IDX > slot)
                begin
                    q_next = left;
                end
                else if (MY_IDX == slot)
                begin
                    q_next = data;
                end
            end
            CELL_EDIT:
            begin
                if (MY_IDX == slot)
                begin
                    q_next = data;
                end
            end
            CELL_ROTATE:
            begin
                q_next = right;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### rtl/core/array_insert_search_edit_engine.sv
// ----------------------------------------------------------------------------
// array_insert_search_edit_engine : ordered array held in a row of cells
// Insert / search / edit / zero-all-matches on a list of signed words.
// ----------------------------------------------------------------------------
// Usage
//   in channel : in_valid / in_stall / in_data (cmd, position, value).
//   out channel: out_valid / out_stall / out_data (match_count, length,
//                status); exactly one result word per command word.
//   Insert and edit act on every cell in the same cycle (shift up or
//   overwrite), so their result is registered in the cycle after the
//   command word is taken and a new word may follow in the next cycle.
//   Search and delete rotate the whole row once through cell 0, which
//   compares against the key (and zeroes on delete) as each entry passes;
//   the result is then handed over from S_DONE once the output is free.
//   in_stall stays high through S_SWEEP and S_DONE.
//   The single result register sets the pace when out_stall is held: no
//   new word is taken until the waiting result has been taken.
//   Reset clears the length, the sequencer and out_valid; cell contents
//   are left as they are, entries at or past the length are never read.
//   Position 0 on insert or edit, and edit past the end, give ST_POS;
//   insert into a full row gives ST_FULL first; insert past the end appends.
// ----------------------------------------------------------------------------
module array_insert_search_edit_engine
    import aise_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  aise_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output aise_out_t out_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // cell index
    localparam int CW = $clog2(DEPTH + 1);                  // length / count
    localparam int SW = ((CW > FIELD_W) ? CW : FIELD_W) + 1; // compare width

    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } fsm_t;

    fsm_t                     state_reg,  state_next;
    logic [CW-1:0]            count_reg,  count_next;
    logic [IW-1:0]            sweep_reg,  sweep_next;
    logic [CW-1:0]            hits_reg,   hits_next;
    logic signed [DATA_W-1:0] key_reg,    key_next;
    logic                     clear_reg,  clear_next;
    logic                     out_valid_reg, out_valid_next;
    aise_out_t                out_reg,    out_next;

    logic                     in_acc;
    logic                     out_free;
    logic [SW-1:0]            pos_w;
    logic [SW-1:0]            cnt_w;
    logic [SW-1:0]            pos_m1;
    logic                     is_full;
    logic                     pos_zero;
    logic                     edit_ok;
    logic [IW-1:0]            ins_slot;
    logic [IW-1:0]            slot;
    cell_op_t                 op;

    logic signed [DATA_W-1:0] cell_q [DEPTH];
    logic signed [DATA_W-1:0] tail;
    logic                     in_range;
    logic                     head_hit;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // command decode
    // ------------------------------------------------------------------
    assign pos_w    = SW'(in_data.position);
    assign cnt_w    = SW'(count_reg);
    assign pos_m1   = pos_w - SW'(1);
    assign is_full  = (count_reg == FULL_CNT);
    assign pos_zero = (in_data.position == '0);
    assign edit_ok  = !pos_zero && (pos_w <= cnt_w);
    // past the end clamps to an append
    assign ins_slot = (pos_m1 > cnt_w) ? IW'(count_reg) : IW'(pos_m1);

    always_comb
    begin
        op   = CELL_HOLD;
        slot = ins_slot;
        if (in_acc)
        begin
            unique case (in_data.cmd)
                CMD_INSERT:
                begin
                    if (!is_full && !pos_zero)
                    begin
                        op = CELL_INSERT;
                    end
                end
                CMD_EDIT:
                begin
                    if (edit_ok)
                    begin
                        op   = CELL_EDIT;
                        slot = IW'(pos_m1);
                    end
                end
                CMD_SEARCH, CMD_DELETE:
                begin
                    op = CELL_HOLD;
                end
            endcase
        end
        else if (state_reg == S_SWEEP)
        begin
            op = CELL_ROTATE;
        end
    end

    // ------------------------------------------------------------------
    // cell row; cell 0 is the compare point during a sweep
    // ------------------------------------------------------------------
    assign in_range = (CW'(sweep_reg) < count_reg);
    assign head_hit = in_range && (cell_q[0] == key_reg);
    assign tail     = (clear_reg && head_hit) ? '0 : cell_q[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = in_data.value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = tail;
        end
        else
        begin : g_mid_r
            assign right_in = cell_q[i+1];
        end

        aise_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk   (clk),
            .op    (op),
            .slot  (slot),
            .data  (in_data.value),
            .left  (left_in),
            .right (right_in),
            .q     (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // sequencer and result register
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        hits_next      = hits_reg;
        key_next       = key_reg;
        clear_next     = clear_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.cmd)
                        CMD_INSERT:
                        begin
                            out_next.match_count = '0;
                            if (is_full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else if (pos_zero)
                            begin
                                out_next.status = ST_POS;
                            end
                            else
                            begin
                                out_next.status = ST_OK;
                                count_next      = count_reg + CW'(1);
                            end
                            out_next.length = FIELD_W'(count_next);
                            out_valid_next  = 1'b1;
                        end
                        CMD_EDIT:
                        begin
                            out_next.match_count = '0;
                            out_next.length      = FIELD_W'(count_reg);
                            out_next.status      = edit_ok ? ST_OK : ST_POS;
                            out_valid_next       = 1'b1;
                        end
                        CMD_SEARCH, CMD_DELETE:
                        begin
                            state_next = S_SWEEP;
                            sweep_next = '0;
                            hits_next  = '0;
                            key_next   = in_data.value;
                            clear_next = (in_data.cmd == CMD_DELETE);
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                hits_next  = hits_reg + CW'(head_hit);
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.match_count = FIELD_W'(hits_reg);
                    out_next.length      = FIELD_W'(count_reg);
                    out_next.status      = ST_OK;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                    sweep_next           = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hits_reg  <= hits_next;
        key_reg   <= key_next;
        clear_reg <= clear_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // a word is only taken while the sequencer is idle
    a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (state_reg == S_IDLE))
        else $error("command taken during a sweep");

    // length never exceeds the row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("length beyond depth");

    // length only ever grows by one, and only through an accepted insert
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) && $past(in_acc)))
        else $error("length changed unexpectedly");

    // sweep index is parked at zero outside a sweep
    a_sweep_park: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (sweep_reg == '0))
        else $error("sweep index not parked");

    // a pending result is not overwritten while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result lost");
`endif

endmodule

### tb/sv/tb_array_insert_search_edit_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_insert_search_edit_engine : self-checking bench for the engine
// Streams command words (insert, search, edit, zero-all-matches) through
// the valid/stall channel. A shadow copy of the array and its length
// works out the reply owed for every word taken. Replies are checked
// field by field, in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_array_insert_search_edit_engine;

    import aise_pkg::*;

    localparam int CELLS = DEPTH_DEF;

    // ------------------------------------------------------------------
    // clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    aise_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    aise_out_t out_data;

    always #1 clk = ~clk;

    array_insert_search_edit_engine #(
        .DEPTH (CELLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // shared state
    // ------------------------------------------------------------------
    aise_in_t  command_backlog [$];   // words waiting to be offered
    aise_out_t owed_replies    [$];   // replies the block still owes
    aise_out_t next_reply;
    aise_out_t want;

    // shadow of the array, updated as each word is taken
    logic signed [DATA_W-1:0] shadow_cells [CELLS];
    int                       shadow_len = 0;

    int gen_len     = 0;     // length as seen by the word generator
    bit quiet       = 1'b0;  // no idling and no stalls while set
    int fault_count = 0;

    // ------------------------------------------------------------------
    // shadow array: apply one command word, give back the reply
    // ------------------------------------------------------------------
    task automatic apply_to_shadow(input aise_in_t word, output aise_out_t reply);
        int      slot;
        int      hits;
        int      j;
        status_t st;
        begin
            hits = 0;
            st   = ST_OK;
            case (word.cmd)
                CMD_INSERT:
                begin
                    // full array wins over a bad position
                    if (shadow_len >= CELLS)
                        st = ST_FULL;
                    else if (word.position == '0)
                        st = ST_POS;
                    else
                    begin
                        slot = int'(word.position) - 1;
                        if (slot > shadow_len)
                            slot = shadow_len;   // past the end: append
                        for (j = shadow_len; j > slot; j--)
                            shadow_cells[j] = shadow_cells[j-1];
                        shadow_cells[slot] = word.value;
                        shadow_len++;
                    end
                end
                CMD_EDIT:
                begin
                    if (word.position == '0 || int'(word.position) > shadow_len
                        || int'(word.position) > CELLS)
                        st = ST_POS;
                    else
                        shadow_cells[int'(word.position) - 1] = word.value;
                end
                default:
                begin
                    // search counts, delete counts and zeroes
                    for (j = 0; j < shadow_len; j++)
                    begin
                        if (shadow_cells[j] == word.value)
                        begin
                            hits++;
                            if (word.cmd == CMD_DELETE)
                                shadow_cells[j] = '0;
                        end
                    end
                end
            endcase
            reply.match_count = FIELD_W'(hits);
            reply.length      = FIELD_W'(shadow_len);
            reply.status      = st;
        end
    endtask

    task automatic report_fault(input string msg);
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("%t ERROR %s", $realtime, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // word generation
    // ------------------------------------------------------------------
    // values lean on a small pool so that search and delete find hits
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 40)
                return DATA_W'($urandom_range(7));
            else if (r < 48)
                return -DATA_W'($urandom_range(4, 1));
            else if (r < 54)
                return 32'sh8000_0000;
            else if (r < 60)
                return 32'sh7fff_ffff;
            else
                return $urandom();
        end
    endfunction

    // mostly in range, with zero, past-the-end and anything at all
    function automatic int pick_position(input int len);
        int r;
        begin
            r = $urandom_range(99);
            if (r < 6)
                return 0;
            else if (r < 14)
                return $urandom_range(1023);
            else if (r < 22)
                return $urandom_range(1023, len + 1);
            else
                return $urandom_range(len + 1, 1);
        end
    endfunction

    task automatic queue_word(input cmd_t c, input int pos,
                              input logic signed [DATA_W-1:0] v);
        aise_in_t w;
        begin
            w.cmd      = c;
            w.position = FIELD_W'(pos);
            w.value    = v;
            if (c == CMD_INSERT && pos != 0 && gen_len < CELLS)
                gen_len++;
            command_backlog.push_back(w);
        end
    endtask

    task automatic queue_random_word();
        int   r;
        cmd_t c;
        begin
            r = $urandom_range(99);
            if (r < 55)
                c = CMD_INSERT;
            else if (r < 70)
                c = CMD_EDIT;
            else if (r < 85)
                c = CMD_SEARCH;
            else
                c = CMD_DELETE;
            // search and delete ignore the position, still toggle it
            queue_word(c, pick_position(gen_len), pick_value());
        end
    endtask

    // wait on the falling edge until every word is taken and answered
    task automatic wait_drained();
        begin
            @(negedge clk);
            while (command_backlog.size() != 0 || in_valid || owed_replies.size() != 0)
                @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers backlog words, holds a word until it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (command_backlog.size() != 0 && (quiet || $urandom_range(99) >= 31))
            begin
                in_valid <= 1'b1;
                in_data  <= command_backlog.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: shadow update on each word taken, then reply check.
    // Both in one block so the queue order never hangs on event order.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_to_shadow(in_data, next_reply);
                owed_replies.push_back(next_reply);
            end
            if (out_valid && !out_stall)
            begin
                if (owed_replies.size() == 0)
                    report_fault($sformatf("reply with none owed: mc=%0d len=%0d st=%0d",
                                           out_data.match_count, out_data.length,
                                           out_data.status));
                else
                begin
                    want = owed_replies.pop_front();
                    if (out_data.match_count !== want.match_count
                        || out_data.length !== want.length
                        || out_data.status !== want.status)
                        report_fault($sformatf(
                            "reply mismatch: want mc=%0d len=%0d st=%0d got mc=%0d len=%0d st=%0d",
                            want.match_count, want.length, want.status,
                            out_data.match_count, out_data.length, out_data.status));
                end
            end
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty array first
        queue_word(CMD_SEARCH, 0, 32'sd5);             // count on empty array
        queue_word(CMD_DELETE, 1023, 32'sd0);
        queue_word(CMD_EDIT, 1, 32'sd9);               // edit with nothing held
        queue_word(CMD_INSERT, 0, 32'sd3);             // position zero
        queue_word(CMD_INSERT, 1023, 32'sh7fff_ffff);  // far past end: append
        queue_word(CMD_INSERT, 1, 32'sh8000_0000);     // at the front
        queue_word(CMD_INSERT, 2, -32'sd1);            // in the middle
        queue_word(CMD_INSERT, 4, 32'sd0);             // exactly one past end
        queue_word(CMD_INSERT, 3, 32'sd5);
        queue_word(CMD_SEARCH, 0, -32'sd1);
        queue_word(CMD_SEARCH, 1023, 32'sh8000_0000);
        queue_word(CMD_EDIT, 0, 32'sd7);               // position zero
        queue_word(CMD_EDIT, 6, 32'sd7);               // just past the end
        queue_word(CMD_EDIT, 1023, 32'sd7);
        queue_word(CMD_EDIT, 5, 32'sd5);               // last entry
        queue_word(CMD_EDIT, 1, 32'sh5555_5555);       // first entry
        queue_word(CMD_SEARCH, 0, 32'sd5);
        queue_word(CMD_DELETE, 0, 32'sd5);             // two zeroed
        queue_word(CMD_SEARCH, 0, 32'sd0);
        queue_word(CMD_DELETE, 0, 32'sh7fff_ffff);
        queue_word(CMD_INSERT, 2, 32'sh2aaa_aaaa);
        queue_word(CMD_SEARCH, 0, 32'sh1234_5678);     // no hits
        // sender holds off until every reply is in
        wait_drained();

        // random, normal idling
        repeat (40) queue_random_word();
        wait_drained();

        // random, neither side idles
        quiet = 1'b1;
        repeat (40) queue_random_word();
        wait_drained();
        quiet = 1'b0;

        repeat (40) queue_random_word();
        wait_drained();

        // fill to the brim with inserts anywhere in the row
        while (gen_len < CELLS)
            queue_word(CMD_INSERT, $urandom_range(99) < 10 ? 1023
                                   : $urandom_range(gen_len + 1, 1), pick_value());
        wait_drained();

        // full array: full status ahead of a bad position, big counts
        queue_word(CMD_INSERT, 1, 32'sd1);
        queue_word(CMD_INSERT, 0, 32'sd1);
        queue_word(CMD_INSERT, 1023, 32'sd1);
        queue_word(CMD_EDIT, CELLS, -32'sd2);
        queue_word(CMD_EDIT, CELLS + 1, -32'sd2);
        queue_word(CMD_SEARCH, 0, 32'sd0);
        queue_word(CMD_DELETE, 0, 32'sd1);
        queue_word(CMD_SEARCH, 0, 32'sd0);
        repeat (10) queue_random_word();
        wait_drained();

        // allow for a late stray reply after a long rotation
        repeat (CELLS + 8) @(posedge clk);
        if (owed_replies.size() != 0)
            report_fault($sformatf("%0d replies never arrived", owed_replies.size()));

        if (fault_count == 0)
            $display("tb_array_insert_search_edit_engine: PASS");
        else
            $display("tb_array_insert_search_edit_engine: FAIL");
        $finish;
    end

    // watchdog: generous cover for an all-search run with stalls
    initial
    begin
        #4_000_000;
        $display("tb_array_insert_search_edit_engine: FAIL");
        $finish;
    end

endmodule
